### rtl/buddy_page_allocator_macros.svh
// Assertion macros for the buddy page allocator.
// Used by buddy_page_allocator.sv; expects clk and rst_n in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("buddy allocator check failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("buddy allocator check failed");

`endif

### rtl/bpa_pkg.sv
// Shared constants for the buddy page allocator: field widths,
// item kinds and status codes. No dependencies.
package bpa_pkg;

  localparam int KIND_W   = 1;
  localparam int REQ_W    = 8;
  localparam int PAGE_W   = 10;
  localparam int STATUS_W = 2;
  localparam int ORDER_W  = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_BLOCK = 2'd1;
  localparam status_t ST_BAD_SIZE = 2'd2;
  localparam status_t ST_UNUSED   = 2'd3;

endpackage

### rtl/buddy_page_allocator.sv
// Buddy page allocator: per-page marks and free-list links in block RAM,
// per-order list heads and counts in flops. Depends on bpa_pkg and
// buddy_page_allocator_macros.svh.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | kind, request_pages, page_index
//  out     | output    | out_valid / out_stall | status, base_page, block_order
//
// One item at a time: in_stall stays high from acceptance until the result is loaded.
// Alloc searches the orders upward from the wanted one, then splits down to it;
// free merges buddies upward before the final push. A list push is S_PUSH0 alone
// on an empty list, else S_PUSH0, S_PUSH1, S_PUSH2 for the prev-link read of the head.
// After reset a clearing pass writes every page's marks and links, with
// in_stall high. A stalled result holds in the output register;
// the next item is taken while it waits.

`include "buddy_page_allocator_macros.svh"

module buddy_page_allocator #(
  parameter int ORDER_LEVELS = 8,
  parameter int POOL_PAGES   = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpa_pkg::KIND_W-1:0]    in_kind,
  input  logic [bpa_pkg::REQ_W-1:0]     in_request_pages,
  input  logic [bpa_pkg::PAGE_W-1:0]    in_page_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpa_pkg::STATUS_W-1:0]  out_status,
  output logic [bpa_pkg::PAGE_W-1:0]    out_base_page,
  output logic [bpa_pkg::ORDER_W-1:0]   out_block_order
);

  localparam int PW        = $clog2(POOL_PAGES);
  localparam int OW        = (ORDER_LEVELS > 2) ? $clog2(ORDER_LEVELS) : 1;
  localparam int CW        = $clog2(POOL_PAGES + 1);
  localparam int MW        = OW + 1;
  localparam int TOP       = ORDER_LEVELS - 1;
  localparam int TOP_PAGES = 1 << TOP;
  localparam int BLOCKS    = POOL_PAGES / TOP_PAGES;
  localparam int LAST_HEAD = (BLOCKS - 1) * TOP_PAGES;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ASRCH   = 4'd2;
  localparam logic [3:0] S_AREM    = 4'd3;
  localparam logic [3:0] S_SPLIT   = 4'd4;
  localparam logic [3:0] S_PUSH0   = 4'd5;
  localparam logic [3:0] S_PUSH1   = 4'd6;
  localparam logic [3:0] S_PUSH2   = 4'd7;
  localparam logic [3:0] S_FCHK    = 4'd8;
  localparam logic [3:0] S_FMERGE  = 4'd9;
  localparam logic [3:0] S_FBCHK   = 4'd10;
  localparam logic [3:0] S_FMARK2  = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  localparam logic [OW-1:0] TOP_ORD = OW'(TOP);

  // mark word: {used, order}
  logic [MW-1:0] mark_mem [POOL_PAGES];
  logic [PW-1:0] next_mem [POOL_PAGES];
  logic [PW-1:0] prev_mem [POOL_PAGES];

  logic          mark_we, next_we, prev_we;
  logic [PW-1:0] mark_wa, next_wa, prev_wa, mark_ra, link_ra;
  logic [MW-1:0] mark_wd, mark_rd_r;
  logic [PW-1:0] next_wd, prev_wd, next_rd_r, prev_rd_r;

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    mark_rd_r <= mark_mem[mark_ra];
    next_rd_r <= next_mem[link_ra];
    prev_rd_r <= prev_mem[link_ra];
  end

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [OW-1:0] lvl_r, lvl_nxt, want_r, want_nxt, push_ord_r, push_ord_nxt;
  logic [PW-1:0] page_r, page_nxt, bud_r, bud_nxt, push_pg_r, push_pg_nxt;
  logic          is_free_r, is_free_nxt;
  logic [PW-1:0] head_r [ORDER_LEVELS];
  logic [PW-1:0] head_nxt [ORDER_LEVELS];
  logic [CW-1:0] count_r [ORDER_LEVELS];
  logic [CW-1:0] count_nxt [ORDER_LEVELS];

  bpa_pkg::status_t         res_status_r, res_status_nxt;
  logic [PW-1:0]            res_page_r, res_page_nxt;
  logic [OW-1:0]            res_order_r, res_order_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bpa_pkg::status_t         out_status_r, out_status_nxt;
  logic [bpa_pkg::PAGE_W-1:0]  out_page_r, out_page_nxt;
  logic [bpa_pkg::ORDER_W-1:0] out_order_r, out_order_nxt;

  logic          in_accept;
  logic [31:0]   pg_ext;
  logic [PW-1:0] pg_in;
  logic [31:0]   want_in;
  logic [PW-1:0] bud_c;
  logic [OW-1:0] lvl_dec, mark_ord;
  logic          init_head;
  logic [PW-1:0] cnt_plus, cnt_minus;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign pg_ext    = 32'(in_page_index);
  assign pg_in     = PW'(pg_ext);
  assign mark_ord  = mark_rd_r[OW-1:0];
  assign lvl_dec   = lvl_r - OW'(1);

  // smallest order whose size covers the request; ORDER_LEVELS if none
  always_comb begin
    want_in = ORDER_LEVELS;
    for (int k = ORDER_LEVELS - 1; k >= 0; k--) begin
      if ((32'd1 << k) >= 32'(in_request_pages)) want_in = k;
    end
  end

  assign init_head = ((32'(cnt_r) & (TOP_PAGES - 1)) == 0) &&
                     (32'(cnt_r) < BLOCKS * TOP_PAGES);
  assign cnt_plus  = (32'(cnt_r) + TOP_PAGES == BLOCKS * TOP_PAGES) ? '0 :
                     PW'(32'(cnt_r) + TOP_PAGES);
  assign cnt_minus = (cnt_r == '0) ? PW'(LAST_HEAD) : PW'(32'(cnt_r) - TOP_PAGES);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    lvl_nxt        = lvl_r;
    want_nxt       = want_r;
    page_nxt       = page_r;
    bud_nxt        = bud_r;
    push_pg_nxt    = push_pg_r;
    push_ord_nxt   = push_ord_r;
    is_free_nxt    = is_free_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_order_nxt  = res_order_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_order_nxt  = out_order_r;
    mark_we = 1'b0; mark_wa = '0; mark_wd = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    mark_ra = '0;
    link_ra = '0;
    bud_c   = '0;

    unique case (state_r)
      S_INIT: begin
        mark_we = 1'b1; mark_wa = cnt_r; mark_wd = {1'b0, TOP_ORD};
        next_we = 1'b1; next_wa = cnt_r; next_wd = init_head ? cnt_plus : '0;
        prev_we = 1'b1; prev_wa = cnt_r; prev_wd = init_head ? cnt_minus : '0;
        cnt_nxt = cnt_r + PW'(1);
        if (32'(cnt_r) == POOL_PAGES - 1) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        mark_ra = pg_in;
        if (in_accept) begin
          is_free_nxt   = (in_kind == bpa_pkg::KIND_FREE);
          res_page_nxt  = '0;
          res_order_nxt = '0;
          if (in_kind == bpa_pkg::KIND_ALLOC) begin
            if (in_request_pages == '0) begin
              res_status_nxt = bpa_pkg::ST_BAD_SIZE;
              state_nxt      = S_DONE;
            end else if (want_in >= ORDER_LEVELS) begin
              res_status_nxt = bpa_pkg::ST_NO_BLOCK;
              state_nxt      = S_DONE;
            end else begin
              want_nxt  = OW'(want_in);
              lvl_nxt   = OW'(want_in);
              state_nxt = S_ASRCH;
            end
          end else begin
            if (pg_ext >= POOL_PAGES) begin
              res_status_nxt = bpa_pkg::ST_UNUSED;
              state_nxt      = S_DONE;
            end else begin
              page_nxt  = pg_in;
              state_nxt = S_FCHK;
            end
          end
        end
      end

      S_ASRCH: begin
        link_ra = head_r[lvl_r];
        if (count_r[lvl_r] != '0) begin
          page_nxt  = head_r[lvl_r];
          state_nxt = S_AREM;
        end else if (lvl_r == TOP_ORD) begin
          res_status_nxt = bpa_pkg::ST_NO_BLOCK;
          state_nxt      = S_DONE;
        end else begin
          lvl_nxt = lvl_r + OW'(1);
        end
      end

      S_AREM: begin
        // block is the list head, so the head moves to its successor
        if (count_r[lvl_r] > CW'(1)) begin
          next_we = 1'b1; next_wa = prev_rd_r; next_wd = next_rd_r;
          prev_we = 1'b1; prev_wa = next_rd_r; prev_wd = prev_rd_r;
          head_nxt[lvl_r] = next_rd_r;
        end
        count_nxt[lvl_r] = count_r[lvl_r] - CW'(1);
        mark_we = 1'b1; mark_wa = page_r; mark_wd = {1'b1, want_r};
        state_nxt = S_SPLIT;
      end

      S_SPLIT: begin
        if (lvl_r > want_r) begin
          bud_c = page_r ^ (PW'(1) << lvl_dec);
          mark_we = 1'b1; mark_wa = bud_c; mark_wd = {1'b0, lvl_dec};
          lvl_nxt      = lvl_dec;
          push_pg_nxt  = bud_c;
          push_ord_nxt = lvl_dec;
          state_nxt    = S_PUSH0;
        end else begin
          res_status_nxt = bpa_pkg::ST_OK;
          res_page_nxt   = page_r;
          res_order_nxt  = want_r;
          state_nxt      = S_DONE;
        end
      end

      S_PUSH0: begin
        link_ra = head_r[push_ord_r];
        if (count_r[push_ord_r] == '0) begin
          next_we = 1'b1; next_wa = push_pg_r; next_wd = push_pg_r;
          prev_we = 1'b1; prev_wa = push_pg_r; prev_wd = push_pg_r;
          head_nxt[push_ord_r]  = push_pg_r;
          count_nxt[push_ord_r] = count_r[push_ord_r] + CW'(1);
          if (is_free_r) begin
            res_status_nxt = bpa_pkg::ST_OK;
            res_page_nxt   = page_r;
            res_order_nxt  = lvl_r;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SPLIT;
          end
        end else begin
          state_nxt = S_PUSH1;
        end
      end

      S_PUSH1: begin
        // prev_rd_r is the tail of the list
        next_we = 1'b1; next_wa = prev_rd_r; next_wd = push_pg_r;
        prev_we = 1'b1; prev_wa = push_pg_r; prev_wd = prev_rd_r;
        state_nxt = S_PUSH2;
      end

      S_PUSH2: begin
        next_we = 1'b1; next_wa = push_pg_r; next_wd = head_r[push_ord_r];
        prev_we = 1'b1; prev_wa = head_r[push_ord_r]; prev_wd = push_pg_r;
        head_nxt[push_ord_r]  = push_pg_r;
        count_nxt[push_ord_r] = count_r[push_ord_r] + CW'(1);
        if (is_free_r) begin
          res_status_nxt = bpa_pkg::ST_OK;
          res_page_nxt   = page_r;
          res_order_nxt  = lvl_r;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SPLIT;
        end
      end

      S_FCHK: begin
        if (!mark_rd_r[OW]) begin
          res_status_nxt = bpa_pkg::ST_UNUSED;
          state_nxt      = S_DONE;
        end else begin
          lvl_nxt = (mark_ord > TOP_ORD) ? TOP_ORD : mark_ord;
          mark_we = 1'b1; mark_wa = page_r; mark_wd = {1'b0, mark_ord};
          state_nxt = S_FMERGE;
        end
      end

      S_FMERGE: begin
        bud_c = page_r ^ (PW'(1) << lvl_r);
        push_pg_nxt  = page_r;
        push_ord_nxt = lvl_r;
        if (lvl_r < TOP_ORD && 32'(bud_c) < POOL_PAGES) begin
          mark_ra   = bud_c;
          link_ra   = bud_c;
          bud_nxt   = bud_c;
          state_nxt = S_FBCHK;
        end else begin
          state_nxt = S_PUSH0;
        end
      end

      S_FBCHK: begin
        if (mark_rd_r[OW] || mark_ord != lvl_r) begin
          state_nxt = S_PUSH0;
        end else begin
          if (count_r[lvl_r] != '0) begin
            if (count_r[lvl_r] > CW'(1)) begin
              next_we = 1'b1; next_wa = prev_rd_r; next_wd = next_rd_r;
              prev_we = 1'b1; prev_wa = next_rd_r; prev_wd = prev_rd_r;
              if (head_r[lvl_r] == bud_r) head_nxt[lvl_r] = next_rd_r;
            end
            count_nxt[lvl_r] = count_r[lvl_r] - CW'(1);
          end
          mark_we = 1'b1; mark_wa = bud_r; mark_wd = {1'b0, lvl_r + OW'(1)};
          state_nxt = S_FMARK2;
        end
      end

      S_FMARK2: begin
        mark_we = 1'b1; mark_wa = page_r; mark_wd = {1'b0, lvl_r + OW'(1)};
        if (bud_r < page_r) page_nxt = bud_r;
        lvl_nxt   = lvl_r + OW'(1);
        state_nxt = S_FMERGE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = bpa_pkg::PAGE_W'(res_page_r);
          out_order_nxt  = bpa_pkg::ORDER_W'(res_order_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < ORDER_LEVELS; k++) begin
        head_r[k]  <= '0;
        count_r[k] <= (k == TOP) ? CW'(BLOCKS) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    want_r       <= want_nxt;
    page_r       <= page_nxt;
    bud_r        <= bud_nxt;
    push_pg_r    <= push_pg_nxt;
    push_ord_r   <= push_ord_nxt;
    is_free_r    <= is_free_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_order_r  <= res_order_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_order_r  <= out_order_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_base_page   = out_page_r;
  assign out_block_order = out_order_r;

  `BPA_ASSERT_NOW(a_init_stalls, state_r == S_INIT, in_stall)
  `BPA_ASSERT_NOW(a_err_zero, out_valid_r && out_status_r != bpa_pkg::ST_OK, ~|{out_page_r, out_order_r})
  `BPA_ASSERT_NOW(a_remove_nonempty, state_r == S_AREM, count_r[lvl_r] != '0)
  `BPA_ASSERT_NEXT(a_accept_busy, in_accept, state_r != S_IDLE)

endmodule

### dv/tb_buddy_page_allocator.sv
// Self-checking testbench for the buddy page allocator: directed and random alloc/free traffic
// checked against an in-bench predictor of the free lists. Depends on bpa_pkg and the RTL.
module tb_buddy_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 8;
  localparam int PAGES  = 1024;
  localparam int TOP    = LEVELS - 1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [bpa_pkg::KIND_W-1:0] kind;
    logic [bpa_pkg::REQ_W-1:0]  req;
    logic [bpa_pkg::PAGE_W-1:0] page;
  } op_t;

  typedef struct packed {
    bpa_pkg::status_t            st;
    logic [bpa_pkg::PAGE_W-1:0]  page;
    logic [bpa_pkg::ORDER_W-1:0] order;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [bpa_pkg::KIND_W-1:0] in_kind = '0;
  logic [bpa_pkg::REQ_W-1:0] in_request_pages = '0;
  logic [bpa_pkg::PAGE_W-1:0] in_page_index = '0;
  logic out_valid, out_stall = 1'b0;
  bpa_pkg::status_t out_status;
  logic [bpa_pkg::PAGE_W-1:0] out_base_page;
  logic [bpa_pkg::ORDER_W-1:0] out_block_order;

  buddy_page_allocator #(.ORDER_LEVELS(LEVELS), .POOL_PAGES(PAGES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_request_pages(in_request_pages), .in_page_index(in_page_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_base_page(out_base_page), .out_block_order(out_block_order)
  );

  always #6 clk = ~clk;

  // predictor state
  bit        pg_used [PAGES];
  int        pg_order[PAGES];
  int        nxt[PAGES], prv[PAGES];
  int        head[LEVELS], cnt[LEVELS];

  op_t    pending_ops[$];
  grant_t expected_grants[$];
  int     live_blocks[$];   // heads currently allocated, for picking valid frees
  int     errors = 0;
  longint cycles = 0;
  int     send_idle_pct = 12, recv_idle_pct = 72;
  int     hold_off = 0;

  function automatic void fl_push(int pg, int ord);
    int h, t;
    if (cnt[ord] == 0) begin
      nxt[pg] = pg; prv[pg] = pg;
    end else begin
      h = head[ord]; t = prv[h];
      nxt[t] = pg; prv[pg] = t; nxt[pg] = h; prv[h] = pg;
    end
    head[ord] = pg;
    cnt[ord]++;
  endfunction

  function automatic void fl_remove(int pg, int ord);
    int n, p;
    if (cnt[ord] == 0) return;
    n = nxt[pg] % PAGES; p = prv[pg] % PAGES;
    if (cnt[ord] > 1) begin
      nxt[p] = n; prv[n] = p;
      if (head[ord] == pg) head[ord] = n;
    end
    cnt[ord]--;
  endfunction

  function automatic void pool_reset();
    int nb;
    nb = PAGES >> TOP;
    for (int i = 0; i < PAGES; i++) begin
      pg_used[i] = 0; pg_order[i] = TOP; nxt[i] = 0; prv[i] = 0;
    end
    for (int k = 0; k < LEVELS; k++) begin
      head[k] = 0; cnt[k] = 0;
    end
    for (int i = 0; i < nb; i++) begin
      nxt[i << TOP] = ((i + 1) % nb) << TOP;
      prv[i << TOP] = ((i + nb - 1) % nb) << TOP;
    end
    cnt[TOP] = nb;
  endfunction

  function automatic grant_t allocate_or_free(op_t op);
    grant_t g;
    int want, cur, blk, bud, ord, idx;
    g = '0;
    if (op.kind == bpa_pkg::KIND_ALLOC) begin
      want = 0;
      while (want < LEVELS && (1 << want) < op.req) want++;
      if (op.req == 0) g.st = bpa_pkg::ST_BAD_SIZE;
      else if (want > TOP) g.st = bpa_pkg::ST_NO_BLOCK;
      else begin
        cur = want;
        while (cur < LEVELS && cnt[cur] == 0) cur++;
        if (cur >= LEVELS) g.st = bpa_pkg::ST_NO_BLOCK;
        else begin
          blk = head[cur] % PAGES;
          fl_remove(blk, cur);
          pg_used[blk] = 1;
          while (cur > want) begin
            cur--;
            bud = (blk ^ (1 << cur)) % PAGES;
            pg_order[bud] = cur; pg_used[bud] = 0;
            fl_push(bud, cur);
          end
          pg_order[blk] = want;
          g.st = bpa_pkg::ST_OK;
          g.page = bpa_pkg::PAGE_W'(blk);
          g.order = bpa_pkg::ORDER_W'(want);
          live_blocks.push_back(blk);
        end
      end
    end else begin
      cur = int'(op.page);
      if (cur >= PAGES || !pg_used[cur]) g.st = bpa_pkg::ST_UNUSED;
      else begin
        ord = pg_order[cur] > TOP ? TOP : pg_order[cur];
        pg_used[cur] = 0;
        for (idx = 0; idx < live_blocks.size(); idx++)
          if (live_blocks[idx] == cur) begin
            live_blocks.delete(idx);
            break;
          end
        while (ord < TOP) begin
          bud = cur ^ (1 << ord);
          if (bud >= PAGES || pg_used[bud] || pg_order[bud] != ord) break;
          fl_remove(bud, ord);
          pg_order[bud] = ord + 1; pg_order[cur] = ord + 1;
          if (bud < cur) cur = bud;
          ord++;
        end
        fl_push(cur, ord);
        g.st = bpa_pkg::ST_OK;
        g.page = bpa_pkg::PAGE_W'(cur);
        g.order = bpa_pkg::ORDER_W'(ord);
      end
    end
    return g;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op_t op;
          op = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_kind <= op.kind; in_request_pages <= op.req; in_page_index <= op.page;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // prediction happens at acceptance so state tracks DUT order
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      op_t op;
      op.kind = in_kind; op.req = in_request_pages; op.page = in_page_index;
      expected_grants.push_back(allocate_or_free(op));
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: st=%0d page=%0d order=%0d",
                                   out_status, out_base_page, out_block_order);
      end else begin
        grant_t e;
        e = expected_grants.pop_front();
        if (e.st !== out_status || e.page !== out_base_page ||
            e.order !== out_block_order) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d page=%0d order=%0d, got st=%0d page=%0d order=%0d",
                     e.st, e.page, e.order, out_status, out_base_page, out_block_order);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_alloc(int req);
    op_t op;
    op = '0;
    op.kind = bpa_pkg::KIND_ALLOC;
    op.req = bpa_pkg::REQ_W'(req);
    op.page = bpa_pkg::PAGE_W'($urandom_range(1023));
    pending_ops.push_back(op);
  endtask

  task automatic push_free(int pg);
    op_t op;
    op = '0;
    op.kind = bpa_pkg::KIND_FREE;
    op.page = bpa_pkg::PAGE_W'(pg);
    op.req = bpa_pkg::REQ_W'($urandom_range(255));
    pending_ops.push_back(op);
  endtask

  // checked at the falling edge, after the driver's updates have settled
  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_grants.size() != 0)
      @(negedge clk);
  endtask

  task automatic random_burst(int n);
    int r, pick;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      // most frees target blocks known live once earlier beats resolve, the rest random pages; alloc if none live
      if (r < 45 || live_blocks.size() == 0) begin
        if ($urandom_range(9) == 0) push_alloc($urandom_range(255));
        else push_alloc($urandom_range(1, 1 << $urandom_range(0, TOP)));
      end else if (r < 92) begin
        drain();
        pick = $urandom_range(live_blocks.size() - 1);
        push_free(live_blocks[pick]);
      end else begin
        push_free($urandom_range(1023));
      end
      if (pending_ops.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    pool_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, errors, deep splits and full merges
    push_alloc(0);
    push_alloc(255);
    push_alloc(129);
    push_alloc(128);
    push_alloc(1);
    push_alloc(2);
    push_alloc(3);
    push_alloc(64);
    push_alloc(65);
    push_free(1023);
    push_free(0);
    push_free(0);
    push_free(128);
    drain();
    while (live_blocks.size() != 0) begin
      push_free(live_blocks[0]);
      drain();
    end
    for (int i = 0; i < 9; i++) push_alloc(128);  // ninth finds nothing
    drain();
    while (live_blocks.size() != 0) begin
      push_free(live_blocks[$]);
      drain();
    end

    random_burst(500);
    // long receiver hold-off while sender keeps offering
    hold_off = 400;
    for (int i = 0; i < 30; i++) push_alloc($urandom_range(1, 8));
    drain();
    send_idle_pct = 72; recv_idle_pct = 12;
    random_burst(550);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_burst(550);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/buddy_page_allocator.sv
dv/tb_buddy_page_allocator.sv
